[sv/scwap_pkg.sv]
// ----------------------------------------------------------------------------
// scwap_pkg: shared definitions for the six-channel weighted average filter
// Sizes, weights, reset values and the control bundle used by the lanes.
// ----------------------------------------------------------------------------
package scwap_pkg;

	// Filter geometry.
	localparam int TAPS         = 5;
	localparam int CHANNELS     = 6;
	localparam int ALL_CHANNELS = 6;
	localparam int SIDE_CHANNELS = 4;

	// Field and datapath widths.
	localparam int SMP_W      = 8;
	localparam int WEIGHT_SUM = (TAPS * (TAPS + 1)) / 2;
	localparam int SUM_MAX    = ((1 << SMP_W) - 1) * WEIGHT_SUM;
	localparam int SUM_W      = $clog2(SUM_MAX + 1);
	localparam int WGT_W      = $clog2(TAPS + 1);
	localparam int PROD_W     = 2 * SUM_W;

	// Reciprocal of the weight sum, scaled by 2^SUM_W. The estimate it gives
	// is low by at most one, so a single compare and increment corrects it.
	localparam int RECIP = (1 << SUM_W) / WEIGHT_SUM;

	// Reset values of the running maxima.
	localparam int PEAK_RESET_SIDE = 190;
	localparam int PEAK_RESET_DIAG = 0;

	// Configuration register map (word index).
	localparam int REG_PEAK_TRACKING = 0;
	localparam int PADDR_W = 3;

	typedef logic [SMP_W-1:0] sample_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [WGT_W-1:0] weight_t;

	// Pipeline loads and mode bits handed from the top level to every lane.
	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic load_s3;
		logic peak_en;
	} lane_ctrl_t;

endpackage

[sv/scwap_if.sv]
// ----------------------------------------------------------------------------
// scwap_if: streaming channels of the weighted average filter
// Sample set channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface scwap_in_if;
	logic                 valid;
	logic                 ready;
	scwap_pkg::sample_t   outer_left_sample;
	scwap_pkg::sample_t   outer_right_sample;
	scwap_pkg::sample_t   inner_left_sample;
	scwap_pkg::sample_t   inner_right_sample;
	scwap_pkg::sample_t   diag_left_sample;
	scwap_pkg::sample_t   diag_right_sample;

	modport source (
		output valid, outer_left_sample, outer_right_sample, inner_left_sample,
		       inner_right_sample, diag_left_sample, diag_right_sample,
		input  ready
	);
	modport sink (
		input  valid, outer_left_sample, outer_right_sample, inner_left_sample,
		       inner_right_sample, diag_left_sample, diag_right_sample,
		output ready
	);
endinterface

interface scwap_out_if;
	logic                 valid;
	logic                 ready;
	scwap_pkg::sample_t   outer_left_avg;
	scwap_pkg::sample_t   outer_right_avg;
	scwap_pkg::sample_t   inner_left_avg;
	scwap_pkg::sample_t   inner_right_avg;
	scwap_pkg::sample_t   diag_left_avg;
	scwap_pkg::sample_t   diag_right_avg;
	scwap_pkg::sample_t   outer_left_peak;
	scwap_pkg::sample_t   outer_right_peak;
	scwap_pkg::sample_t   inner_left_peak;
	scwap_pkg::sample_t   inner_right_peak;
	scwap_pkg::sample_t   diag_left_peak;
	scwap_pkg::sample_t   diag_right_peak;

	modport source (
		output valid, outer_left_avg, outer_right_avg, inner_left_avg,
		       inner_right_avg, diag_left_avg, diag_right_avg, outer_left_peak,
		       outer_right_peak, inner_left_peak, inner_right_peak,
		       diag_left_peak, diag_right_peak,
		input  ready
	);
	modport sink (
		input  valid, outer_left_avg, outer_right_avg, inner_left_avg,
		       inner_right_avg, diag_left_avg, diag_right_avg, outer_left_peak,
		       outer_right_peak, inner_left_peak, inner_right_peak,
		       diag_left_peak, diag_right_peak,
		output ready
	);
endinterface

[sv/scwap_tap_cell.sv]
// ----------------------------------------------------------------------------
// scwap_tap_cell: one tap of the transposed-form weighted sum
// Holds a partial sum; on each accepted sample it adds its weighted copy of
// the sample to the partial sum of its older neighbor.
// ----------------------------------------------------------------------------
module scwap_tap_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  scwap_pkg::weight_t weight,
	input  scwap_pkg::sample_t sample,
	input  scwap_pkg::sum_t    p_in,
	output scwap_pkg::sum_t    p_out
);
	import scwap_pkg::*;

	sum_t p_q;

	// Partial sum; reset to zero so that unfilled history counts as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
		end else if (load) begin
			p_q <= sum_t'(weight) * sum_t'(sample) + p_in;
		end
	end

	assign p_out = p_q;

endmodule

[sv/scwap_lane.sv]
// ----------------------------------------------------------------------------
// scwap_lane: filter lane of one sensor channel
// A chain of tap cells forms the weighted sum, then a reciprocal multiply and
// a correction step divide by the weight sum, and the running peak follows.
// ----------------------------------------------------------------------------
module scwap_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  scwap_pkg::lane_ctrl_t ctrl,
	input  scwap_pkg::sample_t    sample,
	input  scwap_pkg::sample_t    peak_rst,
	output scwap_pkg::sample_t    avg,
	output scwap_pkg::sample_t    peak
);
	import scwap_pkg::*;

	sum_t                p_chain [TAPS+1];
	sum_t                sum_s2;
	sample_t             q_s2;
	sample_t             avg_q;
	sample_t             peak_q;
	logic [PROD_W-1:0]   prod;
	sum_t                rem;
	sample_t             avg_next;

	// The oldest cell sees no older neighbor.
	assign p_chain[TAPS] = '0;

	// Cell k carries weight TAPS-k; cell 0 holds the full sum of the window.
	for (genvar k = 0; k < TAPS; k++) begin : g_tap
		scwap_tap_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (ctrl.load_s1),
			.weight (weight_t'(TAPS - k)),
			.sample (sample),
			.p_in   (p_chain[k+1]),
			.p_out  (p_chain[k])
		);
	end

	// Quotient estimate from the scaled reciprocal.
	assign prod = PROD_W'(p_chain[0]) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (ctrl.load_s2) begin
			sum_s2 <= p_chain[0];
			q_s2   <= sample_t'(prod >> SUM_W);
		end
	end

	// Correction: the estimate is at most one below the true quotient.
	assign rem      = sum_s2 - sum_t'(q_s2) * sum_t'(WEIGHT_SUM);
	assign avg_next = (rem >= sum_t'(WEIGHT_SUM)) ? q_s2 + sample_t'(1) : q_s2;

	// Result register and running maximum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= peak_rst;
		end else if (ctrl.load_s3 && ctrl.peak_en && (avg_next > peak_q)) begin
			peak_q <= avg_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_s3) begin
			avg_q <= avg_next;
		end
	end

	assign avg  = avg_q;
	assign peak = peak_q;

endmodule

[sv/six_channel_weighted_average_peak.sv]
// ----------------------------------------------------------------------------
// six_channel_weighted_average_peak: six-lane weighted moving average with
// running peaks
// A result is registered in the tap cells, the quotient and the result stage.
// Throughput: one sample set per cycle unless the output stalls; the tap-cell
// chains and divide-by-constant pipelines take a new set in every such cycle.
// Reset clears the sample history, sets the outer and inner peaks to 190 and
// the diagonal peaks to 0, and enables peak tracking.
// ----------------------------------------------------------------------------
module six_channel_weighted_average_peak (
	input  logic                           clk,
	input  logic                           arst_n,
	scwap_in_if.sink                       in_ch,
	scwap_out_if.source                    out_ch,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [scwap_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import scwap_pkg::*;

	logic       tracking_q;
	logic       v_s1, v_s2, v_s3;
	logic       rdy1, rdy2, rdy3;
	logic       reg_sel;
	lane_ctrl_t ctrl;
	sample_t    samples [ALL_CHANNELS];
	sample_t    avgs    [ALL_CHANNELS];
	sample_t    peaks   [ALL_CHANNELS];

	// Configuration port: single register at word index zero.
	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1:2] == 1'(REG_PEAK_TRACKING));
	assign prdata  = reg_sel ? {31'b0, tracking_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			tracking_q <= pwdata[0];
		end
	end

	// Stage handshake: a stage takes new data when it is empty or drains.
	assign rdy3 = !v_s3 || out_ch.ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign in_ch.ready  = rdy1;
	assign out_ch.valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_ch.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	assign ctrl.load_s1 = in_ch.valid && rdy1;
	assign ctrl.load_s2 = v_s1 && rdy2;
	assign ctrl.load_s3 = v_s2 && rdy3;
	assign ctrl.peak_en = tracking_q;

	// Gather the sample fields in channel order.
	assign samples[0] = in_ch.outer_left_sample;
	assign samples[1] = in_ch.outer_right_sample;
	assign samples[2] = in_ch.inner_left_sample;
	assign samples[3] = in_ch.inner_right_sample;
	assign samples[4] = in_ch.diag_left_sample;
	assign samples[5] = in_ch.diag_right_sample;

	// One lane per configured channel; missing channels report zero.
	for (genvar c = 0; c < ALL_CHANNELS; c++) begin : g_lane
		if (c < CHANNELS) begin : g_on
			scwap_lane u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.sample   (samples[c]),
				.peak_rst ((c < SIDE_CHANNELS) ? sample_t'(PEAK_RESET_SIDE)
				                               : sample_t'(PEAK_RESET_DIAG)),
				.avg      (avgs[c]),
				.peak     (peaks[c])
			);
		end else begin : g_off
			assign avgs[c]  = '0;
			assign peaks[c] = '0;
		end
	end

	// Scatter the results onto the output fields.
	assign out_ch.outer_left_avg   = avgs[0];
	assign out_ch.outer_right_avg  = avgs[1];
	assign out_ch.inner_left_avg   = avgs[2];
	assign out_ch.inner_right_avg  = avgs[3];
	assign out_ch.diag_left_avg    = avgs[4];
	assign out_ch.diag_right_avg   = avgs[5];
	assign out_ch.outer_left_peak  = peaks[0];
	assign out_ch.outer_right_peak = peaks[1];
	assign out_ch.inner_left_peak  = peaks[2];
	assign out_ch.inner_right_peak = peaks[3];
	assign out_ch.diag_left_peak   = peaks[4];
	assign out_ch.diag_right_peak  = peaks[5];

endmodule

[test/six_channel_weighted_average_peak_test.sv]
// ----------------------------------------------------------------------------
// six_channel_weighted_average_peak_test: self-checking bench for the filter
// Streams sample sets through the six filter lanes under random sender gaps
// and receiver stalls, predicts every result with a behavioral copy of the
// weighted average and peak tracking, and checks each result field by field.
// Peak tracking is switched on and off between phases over the APB port.
// ----------------------------------------------------------------------------
module six_channel_weighted_average_peak_test;
	import scwap_pkg::*;

	localparam int REG_UNMAPPED   = REG_PEAK_TRACKING + 1;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 60;
	localparam int LONG_HOLD      = 120;
	localparam int STALL_LIMIT    = 2000;
	localparam int DRAIN_CYCLES   = 10;

	// One sample per channel, channel 0 is outer left.
	typedef struct packed {
		sample_t [ALL_CHANNELS-1:0] smp;
	} sample_set_t;

	typedef struct packed {
		sample_t [ALL_CHANNELS-1:0] avg;
		sample_t [ALL_CHANNELS-1:0] peak;
	} filter_result_t;

	typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_mode_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	scwap_in_if  sample_bus();
	scwap_out_if result_bus();

	six_channel_weighted_average_peak u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (sample_bus),
		.out_ch  (result_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Sets waiting to be driven and filter results waiting to arrive.
	sample_set_t    pending_sets[$];
	filter_result_t expected_results[$];
	int             sets_queued;
	int             sets_checked;
	int             error_count;
	int             idle_cycles;
	logic           sample_taken;
	int             gap_max;
	int             holds_requested;
	int             holds_served;

	// Behavioral copy of the lane state.
	sample_t tap_history [ALL_CHANNELS][TAPS-1];
	sample_t running_peak [ALL_CHANNELS];
	logic    tracking_on;

	string channel_name [ALL_CHANNELS] = '{"outer_left", "outer_right", "inner_left",
		"inner_right", "diag_left", "diag_right"};

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(string msg);
		$display("MISMATCH: %s", msg);
		error_count++;
	endtask

	// Shifts each sample into its channel window, forms the weighted average
	// and raises the running maximum when tracking is on.
	function automatic filter_result_t filter_sample_set(sample_set_t s);
		filter_result_t r;
		int acc;
		int c;
		int k;
		r = '0;
		for (c = 0; c < CHANNELS && c < ALL_CHANNELS; c++) begin
			acc = TAPS * int'(s.smp[c]);
			for (k = 0; k < TAPS - 1; k++) begin
				acc += (TAPS - 1 - k) * int'(tap_history[c][k]);
			end
			for (k = TAPS - 2; k > 0; k--) begin
				tap_history[c][k] = tap_history[c][k-1];
			end
			tap_history[c][0] = s.smp[c];
			r.avg[c] = sample_t'(acc / WEIGHT_SUM);
			if (tracking_on && r.avg[c] > running_peak[c]) begin
				running_peak[c] = r.avg[c];
			end
			r.peak[c] = running_peak[c];
		end
		return r;
	endfunction

	function automatic sample_set_t uniform_set(int level);
		sample_set_t s;
		int c;
		for (c = 0; c < ALL_CHANNELS; c++) begin
			s.smp[c] = sample_t'(level);
		end
		return s;
	endfunction

	// Mostly independent samples up to the phase level, some with one channel
	// forced to an extreme, some with every channel at the same level.
	function automatic sample_set_t random_sample_set(int level_hi);
		sample_set_t s;
		int pick;
		int c;
		pick = $urandom_range(0, 99);
		if (pick < 90) begin
			for (c = 0; c < ALL_CHANNELS; c++) begin
				s.smp[c] = sample_t'($urandom_range(0, level_hi));
			end
			if (pick >= 75) begin
				c = $urandom_range(0, ALL_CHANNELS - 1);
				s.smp[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
		end else begin
			s = uniform_set($urandom_range(0, level_hi));
		end
		return s;
	endfunction

	task automatic queue_set(sample_set_t s);
		pending_sets.push_back(s);
		sets_queued++;
	endtask

	// Waits until every queued set has produced its checked result.
	task automatic wait_drained();
		while (sets_checked != sets_queued) @(negedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the data at the
	// rising edge of the access cycle.
	task automatic apb_write(int index, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * index);
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_check_tracking();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= PADDR_W'(4 * REG_PEAK_TRACKING);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {31'b0, tracking_on}) begin
			report_mismatch($sformatf("peak_tracking read: got %h, expected %0d",
				prdata, tracking_on));
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Sender: offers queued sets in bursts with gaps, holding each set until
	// its transfer completes.
	always @(negedge clk) begin : sample_source
		sample_set_t next_set;
		logic        offer;
		int          burst_left;
		int          gap_left;
		offer = sample_bus.valid && !sample_taken;
		if (!offer) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_sets.size() > 0) begin
				next_set = pending_sets.pop_front();
				sample_bus.outer_left_sample  <= next_set.smp[0];
				sample_bus.outer_right_sample <= next_set.smp[1];
				sample_bus.inner_left_sample  <= next_set.smp[2];
				sample_bus.inner_right_sample <= next_set.smp[3];
				sample_bus.diag_left_sample   <= next_set.smp[4];
				sample_bus.diag_right_sample  <= next_set.smp[5];
				offer = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 16);
					gap_left   = $urandom_range(0, gap_max);
				end
			end
		end
		sample_bus.valid <= offer;
	end

	// Receiver: stalls on a pattern that changes now and then, and on request
	// holds off for a long stretch.
	always @(negedge clk) begin : result_sink
		logic       take;
		int         hold_left;
		int         mode_left;
		int         pattern_count;
		sink_mode_t sink_mode;
		take = 1'b1;
		if (hold_left > 0) begin
			take = 1'b0;
			hold_left--;
		end else if (holds_served != holds_requested) begin
			holds_served++;
			hold_left = LONG_HOLD - 1;
			take = 1'b0;
		end else begin
			if (mode_left == 0) begin
				sink_mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(30, 150);
			end else begin
				mode_left--;
			end
			case (sink_mode)
				SINK_OPEN:   take = 1'b1;
				SINK_COIN:   take = 1'($urandom_range(0, 1));
				SINK_SPARSE: take = ($urandom_range(0, 3) == 0);
				default:     take = (pattern_count % 3 == 0);
			endcase
			pattern_count++;
		end
		result_bus.ready <= take;
	end

	// Monitor: predicts on every sample set transfer, checks every result
	// transfer, follows register writes and counts cycles without progress.
	always @(posedge clk or negedge arst_n) begin : monitor
		sample_set_t    arrived;
		filter_result_t got;
		filter_result_t want;
		int             c;
		int             k;
		if (!arst_n) begin
			for (c = 0; c < ALL_CHANNELS; c++) begin
				for (k = 0; k < TAPS - 1; k++) begin
					tap_history[c][k] = '0;
				end
				running_peak[c] = sample_t'(c < SIDE_CHANNELS ? PEAK_RESET_SIDE : PEAK_RESET_DIAG);
			end
			tracking_on = 1'b1;
			idle_cycles = 0;
			sample_taken <= 1'b0;
		end else begin
			sample_taken <= sample_bus.valid && sample_bus.ready;
			if (sample_bus.valid && sample_bus.ready) begin
				arrived.smp[0] = sample_bus.outer_left_sample;
				arrived.smp[1] = sample_bus.outer_right_sample;
				arrived.smp[2] = sample_bus.inner_left_sample;
				arrived.smp[3] = sample_bus.inner_right_sample;
				arrived.smp[4] = sample_bus.diag_left_sample;
				arrived.smp[5] = sample_bus.diag_right_sample;
				expected_results.push_back(filter_sample_set(arrived));
			end
			if (result_bus.valid && result_bus.ready) begin
				got.avg[0]  = result_bus.outer_left_avg;
				got.avg[1]  = result_bus.outer_right_avg;
				got.avg[2]  = result_bus.inner_left_avg;
				got.avg[3]  = result_bus.inner_right_avg;
				got.avg[4]  = result_bus.diag_left_avg;
				got.avg[5]  = result_bus.diag_right_avg;
				got.peak[0] = result_bus.outer_left_peak;
				got.peak[1] = result_bus.outer_right_peak;
				got.peak[2] = result_bus.inner_left_peak;
				got.peak[3] = result_bus.inner_right_peak;
				got.peak[4] = result_bus.diag_left_peak;
				got.peak[5] = result_bus.diag_right_peak;
				if (expected_results.size() == 0) begin
					report_mismatch("result transfer with no sample set pending");
				end else begin
					want = expected_results.pop_front();
					for (c = 0; c < ALL_CHANNELS; c++) begin
						if (got.avg[c] !== want.avg[c])
							report_mismatch($sformatf("result %0d %s_avg: got %0d, expected %0d",
								sets_checked, channel_name[c], got.avg[c], want.avg[c]));
						if (got.peak[c] !== want.peak[c])
							report_mismatch($sformatf("result %0d %s_peak: got %0d, expected %0d",
								sets_checked, channel_name[c], got.peak[c], want.peak[c]));
					end
					sets_checked++;
				end
			end
			// Only word index zero is mapped; only its low bit is kept.
			if (psel && penable && pwrite && pready && paddr == PADDR_W'(4 * REG_PEAK_TRACKING)) begin
				tracking_on = pwdata[0];
			end
			if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready)
					|| (psel && penable && pready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
	end

	// Watchdog on cycles without any transfer.
	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
		$display("** six_channel_weighted_average_peak: FAILED **");
		$finish;
	end

	// Stimulus: directed sets, then random phases with varied settings.
	initial begin
		int          ph;
		int          queued;
		int          repeats;
		int          level_hi;
		int          k;
		int          c;
		logic        track_bit;
		sample_set_t next_set;

		sample_bus.valid              = 1'b0;
		sample_bus.outer_left_sample  = '0;
		sample_bus.outer_right_sample = '0;
		sample_bus.inner_left_sample  = '0;
		sample_bus.inner_right_sample = '0;
		sample_bus.diag_left_sample   = '0;
		sample_bus.diag_right_sample  = '0;
		result_bus.ready = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		sets_queued     = 0;
		sets_checked    = 0;
		error_count     = 0;
		gap_max         = 2;
		holds_requested = 0;
		holds_served    = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Tracking off with the upper bits set, and a write to an unmapped
		// register that must leave tracking alone.
		apb_write(REG_PEAK_TRACKING, 32'hFFFF_FFFE);
		apb_write(REG_UNMAPPED, 32'hFFFF_FFFF);
		apb_check_tracking();

		// Warm-up from an empty history to full scale; peaks must hold.
		repeat (5) queue_set(uniform_set(255));
		queue_set(uniform_set(0));
		for (k = 0; k < 2; k++) begin
			for (c = 0; c < ALL_CHANNELS; c++) begin
				next_set.smp[c] = ((c + k) % 2) ? 8'h55 : 8'hAA;
			end
			queue_set(next_set);
		end
		for (k = 0; k < 2; k++) begin
			for (c = 0; c < ALL_CHANNELS; c++) begin
				next_set.smp[c] = sample_t'(k ? 255 - 51 * c : 51 * c);
			end
			queue_set(next_set);
		end
		wait_drained();

		// Tracking on: side channels climb through their reset peak, the
		// diagonal channels climb up from zero.
		apb_write(REG_PEAK_TRACKING, 32'h0000_0001);
		apb_check_tracking();
		for (k = 0; k < 12; k++) begin
			for (c = 0; c < ALL_CHANNELS; c++) begin
				next_set.smp[c] = sample_t'(c < SIDE_CHANNELS ? 150 + 5 * k : 10 + 5 * k);
			end
			queue_set(next_set);
		end

		// Random phases: each starts from an idle block with a new setting.
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_drained();
			track_bit = (ph % 3 != 1);
			apb_write(REG_PEAK_TRACKING, ($urandom() & 32'hFFFF_FFFE) | 32'(track_bit));
			if (ph % 3 == 2) apb_write(REG_UNMAPPED, $urandom());
			apb_check_tracking();
			gap_max  = (ph % 3 == 0) ? 0 : $urandom_range(1, 8);
			level_hi = (ph < 5) ? 80 + 40 * ph : 255;
			// Long receiver hold while the sender keeps offering.
			if (ph == 3) holds_requested++;
			queued = 0;
			while (queued < PHASE_ITEMS) begin
				next_set = random_sample_set(level_hi);
				// A steady run repeats one value; a run of TAPS or more fills the whole window.
				repeats = ($urandom_range(0, 99) < 15) ? $urandom_range(4, 8) : 1;
				repeat (repeats) begin
					queue_set(next_set);
					queued++;
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_results.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		end
		if (error_count == 0) begin
			$display("** six_channel_weighted_average_peak: PASSED **");
		end else begin
			$display("** six_channel_weighted_average_peak: FAILED **");
		end
		$finish;
	end

endmodule

[sim.f]
sv/scwap_pkg.sv
sv/scwap_if.sv
sv/scwap_tap_cell.sv
sv/scwap_lane.sv
sv/six_channel_weighted_average_peak.sv
test/six_channel_weighted_average_peak_test.sv
